>>> hdl/bvm_pkg.sv
// Shared types, opcodes and helpers for the byte VM instruction step core.
package bvm_pkg;

  localparam int MEM_DEPTH_DEF = 256;
  localparam int NUM_REGS      = 5;
  localparam int REG_IW        = 3;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_STEP  = 2'd1;
  localparam logic [1:0] ACT_EXEC  = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [7:0] OP_HALT  = 8'h00;
  localparam logic [7:0] OP_STI   = 8'h01;
  localparam logic [7:0] OP_JMP   = 8'h02;
  localparam logic [7:0] OP_BIOS  = 8'h03;
  localparam logic [7:0] OP_LDI_A = 8'h04;
  localparam logic [7:0] OP_LDI_B = 8'h05;
  localparam logic [7:0] OP_LDI_C = 8'h06;
  localparam logic [7:0] OP_LDI_D = 8'h07;
  localparam logic [7:0] OP_LDI_S = 8'h08;
  localparam logic [7:0] OP_ADD   = 8'h09;
  localparam logic [7:0] OP_STR   = 8'h0A;
  localparam logic [7:0] OP_LDR   = 8'h0B;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] address;
    logic [7:0] data;
    logic [7:0] opcode;
  } in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] prog_counter;
    logic [7:0] reg_a;
    logic [7:0] reg_b;
    logic [7:0] reg_c;
    logic [7:0] reg_d;
    logic [7:0] reg_s;
    logic       halted;
    logic       unknown_op;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_FETCH_OP,
    ST_FETCH_M1,
    ST_FETCH_M2,
    ST_EXECUTE,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       wr_item;
    logic       rd_item;
    logic       rd_pc;
    logic [1:0] pc_off;
    logic       take_op;
    logic       take_m1;
    logic       exec;
    logic       load;
    logic       fin_read;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       load_needed;
  } sts_t;

  // byte address reduced modulo depth; quotient never exceeds 15 for depth >= 16
  function automatic logic [7:0] mem_index(input logic [7:0] a, input int depth);
    int v;
    v = int'(a);
    for (int k = 3; k >= 0; k--) begin
      if (v >= (depth << k)) begin
        v = v - (depth << k);
      end
    end
    return v[7:0];
  endfunction

endpackage

>>> hdl/bvm_ctrl.sv
// Sequencing state machine for the byte VM instruction step core.
module bvm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [1:0]    in_action,
  input  bvm_pkg::sts_t sts,
  output logic          busy,
  output bvm_pkg::cmd_t cmd
);

  bvm_pkg::state_t state_r;
  bvm_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bvm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      bvm_pkg::ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          case (in_action)
            bvm_pkg::ACT_WRITE: state_nxt = bvm_pkg::ST_WRITE;
            bvm_pkg::ACT_STEP:  state_nxt = bvm_pkg::ST_FETCH_OP;
            bvm_pkg::ACT_EXEC:  state_nxt = bvm_pkg::ST_FETCH_M1;
            bvm_pkg::ACT_READ:  state_nxt = bvm_pkg::ST_READ;
            default:            state_nxt = bvm_pkg::ST_READ;
          endcase
        end
      end
      bvm_pkg::ST_WRITE: begin
        cmd.wr_item = 1'b1;
        cmd.done    = 1'b1;
        state_nxt   = bvm_pkg::ST_IDLE;
      end
      bvm_pkg::ST_READ: begin
        cmd.rd_item = 1'b1;
        state_nxt   = bvm_pkg::ST_READ_WAIT;
      end
      bvm_pkg::ST_READ_WAIT: begin
        cmd.fin_read = 1'b1;
        cmd.done     = 1'b1;
        state_nxt    = bvm_pkg::ST_IDLE;
      end
      bvm_pkg::ST_FETCH_OP: begin
        cmd.rd_pc  = 1'b1;
        cmd.pc_off = 2'd0;
        state_nxt  = bvm_pkg::ST_FETCH_M1;
      end
      bvm_pkg::ST_FETCH_M1: begin
        cmd.rd_pc   = 1'b1;
        cmd.pc_off  = 2'd1;
        cmd.take_op = (sts.action == bvm_pkg::ACT_STEP);
        state_nxt   = bvm_pkg::ST_FETCH_M2;
      end
      bvm_pkg::ST_FETCH_M2: begin
        cmd.rd_pc   = 1'b1;
        cmd.pc_off  = 2'd2;
        cmd.take_m1 = 1'b1;
        state_nxt   = bvm_pkg::ST_EXECUTE;
      end
      bvm_pkg::ST_EXECUTE: begin
        cmd.exec = 1'b1;
        if (sts.load_needed) begin
          state_nxt = bvm_pkg::ST_LOAD;
        end else begin
          cmd.done  = 1'b1;
          state_nxt = bvm_pkg::ST_IDLE;
        end
      end
      bvm_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        cmd.done  = 1'b1;
        state_nxt = bvm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bvm_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != bvm_pkg::ST_IDLE);

endmodule

>>> hdl/bvm_datapath.sv
// Memory, register file, program counter and result register of the byte VM.
module bvm_datapath #(
  parameter int MEM_DEPTH = bvm_pkg::MEM_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bvm_pkg::in_t  in_item,
  input  bvm_pkg::cmd_t cmd,
  output bvm_pkg::sts_t sts,
  output logic          out_valid,
  output bvm_pkg::out_t out_item
);

  localparam int AW = $clog2(MEM_DEPTH);

  logic [7:0]           mem_r [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [7:0]           rd_r;

  logic [7:0] regs_r [bvm_pkg::NUM_REGS];
  logic [7:0] pc_r;
  logic       halt_r;
  logic       unk_r;
  logic [7:0] rdo_r;
  logic       out_valid_r;

  logic [1:0] act_r;
  logic [7:0] addr_r;
  logic [7:0] data_r;
  logic [7:0] op_r;
  logic [7:0] m1_r;

  logic [7:0]    maddr;
  logic [7:0]    mred;
  logic [AW-1:0] midx;
  logic [7:0]    wdata;
  logic          mem_we;
  logic          mem_re;
  logic          sel_ok;
  logic [7:0]    reg_sel;
  logic [7:0]    ldi_off;

  assign sel_ok  = (m1_r < 8'(bvm_pkg::NUM_REGS));
  assign reg_sel = sel_ok ? regs_r[m1_r[bvm_pkg::REG_IW-1:0]] : 8'd0;
  assign ldi_off = op_r - bvm_pkg::OP_LDI_A;

  always_comb begin
    if (cmd.wr_item || cmd.rd_item) begin
      maddr = addr_r;
    end else if (cmd.rd_pc) begin
      maddr = pc_r + {6'd0, cmd.pc_off};
    end else if (op_r == bvm_pkg::OP_STI) begin
      maddr = m1_r;
    end else begin
      maddr = rd_r;
    end
  end

  assign mred = bvm_pkg::mem_index(maddr, MEM_DEPTH);
  assign midx = mred[AW-1:0];

  assign wdata  = cmd.wr_item ? data_r : ((op_r == bvm_pkg::OP_STI) ? rd_r : reg_sel);
  assign mem_we = cmd.wr_item ||
                  (cmd.exec && ((op_r == bvm_pkg::OP_STI) ||
                                ((op_r == bvm_pkg::OP_STR) && sel_ok)));
  assign mem_re = cmd.rd_item || cmd.rd_pc ||
                  (cmd.exec && (op_r == bvm_pkg::OP_LDR) && sel_ok);

  assign sts.action      = act_r;
  assign sts.load_needed = (op_r == bvm_pkg::OP_LDR) && sel_ok;

  // per-entry valid bits give the all-zero reset image
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[midx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[midx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_r <= vld_r[midx] ? mem_r[midx] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r  <= in_item.action;
      addr_r <= in_item.address;
      data_r <= in_item.data;
      op_r   <= in_item.opcode;
    end else if (cmd.take_op) begin
      op_r <= rd_r;
    end
    if (cmd.take_m1) begin
      m1_r <= rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= 8'd0;
      halt_r      <= 1'b0;
      unk_r       <= 1'b0;
      rdo_r       <= 8'd0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < bvm_pkg::NUM_REGS; i++) begin
        regs_r[i] <= 8'd0;
      end
    end else begin
      out_valid_r <= cmd.done;
      if (cmd.accept) begin
        unk_r <= 1'b0;
        rdo_r <= 8'd0;
      end
      if (cmd.fin_read) begin
        rdo_r <= rd_r;
      end
      if (cmd.exec) begin
        // rd_r holds the second operand here
        case (op_r)
          bvm_pkg::OP_HALT: begin
            halt_r <= 1'b1;
          end
          bvm_pkg::OP_STI: begin
            pc_r <= pc_r + 8'd3;
          end
          bvm_pkg::OP_JMP: begin
            pc_r <= m1_r;
          end
          bvm_pkg::OP_BIOS: begin
            pc_r <= pc_r;
          end
          bvm_pkg::OP_LDI_A, bvm_pkg::OP_LDI_B, bvm_pkg::OP_LDI_C,
          bvm_pkg::OP_LDI_D, bvm_pkg::OP_LDI_S: begin
            regs_r[ldi_off[bvm_pkg::REG_IW-1:0]] <= m1_r;
            pc_r <= pc_r + 8'd2;
          end
          bvm_pkg::OP_ADD: begin
            if (sel_ok) begin
              regs_r[m1_r[bvm_pkg::REG_IW-1:0]] <= reg_sel + rd_r;
            end
            pc_r <= pc_r + 8'd3;
          end
          bvm_pkg::OP_STR, bvm_pkg::OP_LDR: begin
            pc_r <= pc_r + 8'd3;
          end
          default: begin
            pc_r  <= pc_r + 8'd1;
            unk_r <= 1'b1;
          end
        endcase
      end
      if (cmd.load) begin
        regs_r[m1_r[bvm_pkg::REG_IW-1:0]] <= rd_r;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_item.read_data    = rdo_r;
  assign out_item.prog_counter = pc_r;
  assign out_item.reg_a        = regs_r[0];
  assign out_item.reg_b        = regs_r[1];
  assign out_item.reg_c        = regs_r[2];
  assign out_item.reg_d        = regs_r[3];
  assign out_item.reg_s        = regs_r[4];
  assign out_item.halted       = halt_r;
  assign out_item.unknown_op   = unk_r;

endmodule

>>> hdl/byte_vm_instruction_step_core.sv
// From acceptance, a write passes ST_WRITE; a read ST_READ then ST_READ_WAIT; a supplied
// opcode ST_FETCH_M1, ST_FETCH_M2, ST_EXECUTE (and ST_LOAD for load indirect); a step from
// memory starts at ST_FETCH_OP. The strobe is registered after the last state; a new beat is
// taken in the strobe cycle. Single-port memory: opcode, two operands, one data access in turn.
// Synchronous active-low reset clears pc, registers, halt flag and memory valid bits.
// Results are strobed for one cycle; the receiver cannot stall.
module byte_vm_instruction_step_core #(
  parameter int MEM_DEPTH = bvm_pkg::MEM_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  bvm_pkg::in_t  in_item,
  output logic          out_valid,
  output bvm_pkg::out_t out_item
);

  bvm_pkg::cmd_t cmd;
  bvm_pkg::sts_t sts;

  bvm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_item.action),
    .sts       (sts),
    .busy      (busy),
    .cmd       (cmd)
  );

  bvm_datapath #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

>>> hdl/bvm_checker.sv
// Port-level checks for the byte VM instruction step core, bound to the top level.
module bvm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input bvm_pkg::in_t  in_item,
  input logic          out_valid,
  input bvm_pkg::out_t out_item
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_fell_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result strobe");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && !$past(out_valid)))
    else $error("result strobe while busy or two strobes in a row");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.halted |=> out_item.halted)
    else $error("halted flag cleared without reset");

  a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.action != bvm_pkg::ACT_READ)) |=> ##1
      (out_item.read_data == 8'd0))
    else $error("read data nonzero for a non-read beat");

endmodule

bind byte_vm_instruction_step_core bvm_checker u_bvm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);
